// ===== rtl/hsl_pkg.sv =====
// shared constants, types and pipeline control for the hsl to rgb converter
// no dependencies; every other file refers to it by scoped names
package hsl_pkg;

  localparam int HueBits   = 16;
  localparam int FracBits  = 16;
  localparam int QW        = FracBits + 1;
  localparam int NumStages = 5;

  localparam logic [QW-1:0]       OneQ           = QW'(65536);
  localparam logic [QW-1:0]       HalfQ          = QW'(32768);
  localparam logic [FracBits-1:0] ThirdQ         = FracBits'(21845);
  localparam logic [FracBits-1:0] TwoThirdsQ     = FracBits'(43691);
  localparam logic [FracBits-1:0] SixthLimit     = FracBits'(10923);
  localparam logic [FracBits-1:0] TwoThirdsLimit = FracBits'(43691);
  localparam logic [18:0]         FourQ          = 19'(262144);
  localparam logic [7:0]          ByteMax        = 8'd255;

  typedef enum logic [1:0] {
    SegRise,
    SegHigh,
    SegFall,
    SegLow
  } ramp_seg_e;

  typedef struct packed {
    ramp_seg_e       seg;
    logic [QW-1:0]   factor;
  } chan_stage_t;

  typedef struct packed {
    logic [NumStages-1:0] en;
  } pipe_en_t;

endpackage

// ===== rtl/hsl_if.sv =====
// valid/ready channel interfaces for the hsl input word and the rgb output word
// depends on hsl_pkg
interface hsl_in_if;
  logic                         valid;
  logic                         ready;
  logic [hsl_pkg::HueBits-1:0]  hue_turn;
  logic [7:0]                   saturation_level;
  logic [7:0]                   lightness_level;

  modport source (output valid, hue_turn, saturation_level, lightness_level, input ready);
  modport sink   (input valid, hue_turn, saturation_level, lightness_level, output ready);
endinterface

interface hsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== rtl/hsl_prep.sv =====
// stages one and two: q16 scaling, lightness times saturation, q and p,
// and per-channel ramp segment and slope factor; depends on hsl_pkg
module hsl_prep (
  input  logic                                clk_i,
  input  hsl_pkg::pipe_en_t                   en_i,
  input  logic [hsl_pkg::HueBits-1:0]         hue_i,
  input  logic [7:0]                          sat_i,
  input  logic [7:0]                          lit_i,
  output logic [hsl_pkg::QW-1:0]              p_o,
  output logic [hsl_pkg::QW-1:0]              q_o,
  output logic [hsl_pkg::QW-1:0]              d_o,
  output hsl_pkg::chan_stage_t [2:0]          ch_o
);

  localparam int QW = hsl_pkg::QW;
  localparam int FB = hsl_pkg::FracBits;
  localparam int HB = hsl_pkg::HueBits;

  logic [FB-1:0]   h_d, h_q;
  logic [QW-1:0]   s_d, s_q, l_d, l_q, ls_d, ls_q;
  logic [2*QW-1:0] ls_full;
  logic [HB+FB-1:0] hue_ext;

  logic [QW-1:0]   q_d, q_r, p_d, p_r, d_d, d_r;
  hsl_pkg::chan_stage_t [2:0] ch_d, ch_q;

  // byte * 65536 / 255 is byte * 257 plus one at full scale
  always_comb begin
    hue_ext = {hue_i, FB'(0)};
    h_d     = hue_ext[HB +: FB];
    s_d     = {1'b0, sat_i, sat_i} + QW'(sat_i == 8'hff);
    l_d     = {1'b0, lit_i, lit_i} + QW'(lit_i == 8'hff);
    ls_full = s_d * l_d;
    ls_d    = ls_full[FB +: QW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en[0]) begin
      h_q  <= h_d;
      s_q  <= s_d;
      l_q  <= l_d;
      ls_q <= ls_d;
    end
  end

  always_comb begin
    logic [QW:0]     q_sum;
    logic signed [QW+1:0] p_diff;
    logic [FB-1:0]   t [3];
    logic [18:0]     six_t;
    q_sum = (l_q < hsl_pkg::HalfQ) ? ({1'b0, l_q} + {1'b0, ls_q})
                                   : ({1'b0, l_q} + {1'b0, s_q} - {1'b0, ls_q});
    q_d = (q_sum > {1'b0, hsl_pkg::OneQ}) ? hsl_pkg::OneQ : q_sum[QW-1:0];
    p_diff = $signed({1'b0, l_q, 1'b0}) - $signed({2'b00, q_d});
    if (p_diff < 0) begin
      p_d = '0;
    end else if (p_diff > $signed({2'b00, hsl_pkg::OneQ})) begin
      p_d = hsl_pkg::OneQ;
    end else begin
      p_d = p_diff[QW-1:0];
    end
    d_d = (q_d >= p_d) ? (q_d - p_d) : '0;
    t[0] = h_q + hsl_pkg::ThirdQ;
    t[1] = h_q;
    t[2] = h_q + hsl_pkg::TwoThirdsQ;
    for (int i = 0; i < 3; i++) begin
      six_t = 19'(t[i]) * 19'd6;
      if (t[i] < hsl_pkg::SixthLimit) begin
        ch_d[i].seg    = hsl_pkg::SegRise;
        ch_d[i].factor = six_t[QW-1:0];
      end else if (17'(t[i]) < hsl_pkg::HalfQ) begin
        ch_d[i].seg    = hsl_pkg::SegHigh;
        ch_d[i].factor = '0;
      end else if (t[i] < hsl_pkg::TwoThirdsLimit) begin
        ch_d[i].seg    = hsl_pkg::SegFall;
        ch_d[i].factor = 17'(hsl_pkg::FourQ - six_t);
      end else begin
        ch_d[i].seg    = hsl_pkg::SegLow;
        ch_d[i].factor = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en[1]) begin
      q_r  <= q_d;
      p_r  <= p_d;
      d_r  <= d_d;
      ch_q <= ch_d;
    end
  end

  assign p_o  = p_r;
  assign q_o  = q_r;
  assign d_o  = d_r;
  assign ch_o = ch_q;

endmodule

// ===== rtl/hsl_chan.sv =====
// stages three to five for one color channel: slope multiply, ramp value,
// scale by 255 to a byte; depends on hsl_pkg
module hsl_chan (
  input  logic                     clk_i,
  input  hsl_pkg::pipe_en_t        en_i,
  input  hsl_pkg::chan_stage_t     ch_i,
  input  logic [hsl_pkg::QW-1:0]   p_i,
  input  logic [hsl_pkg::QW-1:0]   q_i,
  input  logic [hsl_pkg::QW-1:0]   d_i,
  output logic [7:0]               byte_o
);

  localparam int QW = hsl_pkg::QW;
  localparam int FB = hsl_pkg::FracBits;

  logic [2*QW-1:0]    prod_d, prod_q;
  hsl_pkg::ramp_seg_e seg_q;
  logic [QW-1:0]      p_q, q_q;
  logic [QW-1:0]      v_d, v_q;
  logic [7:0]         byte_d, byte_q;

  assign prod_d = d_i * ch_i.factor;

  always_ff @(posedge clk_i) begin
    if (en_i.en[2]) begin
      prod_q <= prod_d;
      seg_q  <= ch_i.seg;
      p_q    <= p_i;
      q_q    <= q_i;
    end
  end

  always_comb begin
    logic [QW:0] sum;
    sum = {1'b0, p_q} + prod_q[FB +: QW+1];
    case (seg_q)
      hsl_pkg::SegRise, hsl_pkg::SegFall: begin
        v_d = (sum > (QW+1)'(hsl_pkg::OneQ)) ? hsl_pkg::OneQ : sum[QW-1:0];
      end
      hsl_pkg::SegHigh: v_d = q_q;
      hsl_pkg::SegLow:  v_d = p_q;
      default:          v_d = p_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en[3]) begin
      v_q <= v_d;
    end
  end

  always_comb begin
    logic [QW+7:0] scaled;
    logic [QW+7-FB:0] top;
    scaled = {v_q, 8'h00} - {8'h00, v_q};
    top    = scaled[QW+7:FB];
    byte_d = (top > (QW+8-FB)'(hsl_pkg::ByteMax)) ? hsl_pkg::ByteMax : top[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en[4]) begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

// ===== rtl/hsl_to_rgb_converter_top.sv =====
// hsl to rgb converter top level: stage valid bits, stall control, gray bypass
// depends on hsl_pkg, hsl_if, hsl_prep and hsl_chan
//
// usage:
//   hsl_i  takes one word per cycle unless stalled: hue_turn (fraction of a
//          turn), saturation_level and lightness_level (255 is full scale)
//   rgb_o  returns one word per input word: red_out, green_out, blue_out
//   a word moves on a rising clock edge with valid and ready both high
//   a word passes every registered stage from input acceptance to output valid;
//   throughput is one word per cycle unless stalled, set by the five-stage
//   pipeline, one 17x17 multiply in stage one, one per channel in stage three
//   each stage keeps its own valid bit and loads whenever it is empty or the
//   stage after it moves, so bubbles close up while the receiver stalls;
//   hsl_i.ready drops only once all five stages hold words
//   a stalled output word holds its value until taken
//   zero saturation returns lightness on all three channels
//   reset empties the pipeline; no words are lost or repeated
module hsl_to_rgb_converter_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  hsl_in_if.sink           hsl_i,
  hsl_out_if.source        rgb_o
);

  localparam int NS = hsl_pkg::NumStages;
  localparam int QW = hsl_pkg::QW;

  hsl_pkg::pipe_en_t          en;
  logic [NS-1:0]              vld_d, vld_q;
  logic [NS-1:0]              gray_q;
  logic [7:0]                 lit_q [NS];
  logic [QW-1:0]              p, q, d;
  hsl_pkg::chan_stage_t [2:0] ch;
  logic [7:0]                 chan_byte [3];

  always_comb begin
    en.en[NS-1] = !vld_q[NS-1] || rgb_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en.en[k] = !vld_q[k] || en.en[k+1];
    end
    vld_d = vld_q;
    if (en.en[0]) begin
      vld_d[0] = hsl_i.valid;
    end
    for (int k = 1; k < NS; k++) begin
      if (en.en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // gray bypass travels beside the color path
  always_ff @(posedge clk_i) begin
    if (en.en[0]) begin
      gray_q[0] <= (hsl_i.saturation_level == 8'h00);
      lit_q[0]  <= hsl_i.lightness_level;
    end
    for (int k = 1; k < NS; k++) begin
      if (en.en[k]) begin
        gray_q[k] <= gray_q[k-1];
        lit_q[k]  <= lit_q[k-1];
      end
    end
  end

  hsl_prep u_prep (
    .clk_i (clk_i),
    .en_i  (en),
    .hue_i (hsl_i.hue_turn),
    .sat_i (hsl_i.saturation_level),
    .lit_i (hsl_i.lightness_level),
    .p_o   (p),
    .q_o   (q),
    .d_o   (d),
    .ch_o  (ch)
  );

  for (genvar c = 0; c < 3; c++) begin : g_chan
    hsl_chan u_chan (
      .clk_i  (clk_i),
      .en_i   (en),
      .ch_i   (ch[c]),
      .p_i    (p),
      .q_i    (q),
      .d_i    (d),
      .byte_o (chan_byte[c])
    );
  end

  assign hsl_i.ready     = en.en[0];
  assign rgb_o.valid     = vld_q[NS-1];
  assign rgb_o.red_out   = gray_q[NS-1] ? lit_q[NS-1] : chan_byte[0];
  assign rgb_o.green_out = gray_q[NS-1] ? lit_q[NS-1] : chan_byte[1];
  assign rgb_o.blue_out  = gray_q[NS-1] ? lit_q[NS-1] : chan_byte[2];

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for hsl_to_rgb_converter_top: directed and random colors,
// predicted rgb words checked in order under varying sender and receiver gaps
// depends on hsl_pkg, hsl_if and the converter rtl
module testbench;

  localparam int                NumStages      = hsl_pkg::NumStages;
  localparam int                HueBits        = hsl_pkg::HueBits;
  localparam int                FracBits       = hsl_pkg::FracBits;
  localparam logic [16:0]       OneQ           = hsl_pkg::OneQ;
  localparam logic [16:0]       HalfQ          = hsl_pkg::HalfQ;
  localparam logic [15:0]       ThirdQ         = hsl_pkg::ThirdQ;
  localparam logic [15:0]       TwoThirdsQ     = hsl_pkg::TwoThirdsQ;
  localparam logic [15:0]       SixthLimit     = hsl_pkg::SixthLimit;
  localparam logic [15:0]       TwoThirdsLimit = hsl_pkg::TwoThirdsLimit;
  localparam logic [18:0]       FourQ          = hsl_pkg::FourQ;
  localparam logic [7:0]        ByteMax        = hsl_pkg::ByteMax;

  localparam int RandomColors = 530;
  localparam int PhaseWords   = 70;
  localparam int QuietLimit   = 2000;
  localparam int DrainCycles  = 4 * NumStages;

  typedef struct packed {
    logic [HueBits-1:0] hue;
    logic [7:0]         sat;
    logic [7:0]         lit;
  } hsl_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  typedef enum logic [1:0] {
    GapNone,
    GapSender,
    GapReceiver,
    GapBoth
  } gap_mode_e;

  logic        clk_i;
  logic        rst_ni;
  hsl_word_t   hsl_pending[$];
  rgb_word_t   rgb_due[$];
  int unsigned words_sent;
  int unsigned error_count;
  int unsigned quiet_cycles;
  gap_mode_e   gap_mode;

  hsl_in_if  hsl_bus ();
  hsl_out_if rgb_bus ();

  hsl_to_rgb_converter_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsl_i  (hsl_bus),
    .rgb_o  (rgb_bus)
  );

  assign gap_mode = gap_mode_e'((words_sent / PhaseWords) % 4);

  function automatic logic [16:0] byte_to_frac(logic [7:0] b);
    logic [23:0] scaled;
    scaled = {b, 16'h0000} / 24'd255;
    return scaled[16:0];
  endfunction

  function automatic logic [16:0] hue_ramp(logic [16:0] p, logic [16:0] q,
                                           logic [FracBits-1:0] t);
    logic [63:0] d;
    logic [63:0] v;
    d = (q >= p) ? 64'(q - p) : 64'd0;
    if (t < SixthLimit) begin
      v = 64'(p) + ((d * 64'd6 * 64'(t)) >> FracBits);
    end else if (t < HalfQ) begin
      v = 64'(q);
    end else if (t < TwoThirdsLimit) begin
      v = 64'(p) + ((d * (64'(FourQ) - 64'd6 * 64'(t))) >> FracBits);
    end else begin
      v = 64'(p);
    end
    if (v > 64'(OneQ)) v = 64'(OneQ);
    return v[16:0];
  endfunction

  function automatic logic [7:0] frac_to_byte(logic [16:0] v);
    logic [63:0] c;
    c = (64'(v) * 64'(ByteMax)) >> FracBits;
    return (c > 64'(ByteMax)) ? ByteMax : c[7:0];
  endfunction

  function automatic rgb_word_t predict_rgb(hsl_word_t w);
    rgb_word_t           r;
    logic [FracBits-1:0] h;
    logic [16:0]         s;
    logic [16:0]         l;
    logic [16:0]         q;
    logic [16:0]         p;
    longint              ls;
    longint              qv;
    longint              pv;
    if (w.sat == 8'd0) begin
      r.red   = w.lit;
      r.green = w.lit;
      r.blue  = w.lit;
      return r;
    end
    // hue rescaled to a 16-bit fraction of a turn
    h  = FracBits'({w.hue, 16'h0000} >> HueBits);
    s  = byte_to_frac(w.sat);
    l  = byte_to_frac(w.lit);
    ls = longint'((64'(l) * 64'(s)) >> FracBits);
    if (l < HalfQ) qv = longint'(l) + ls;
    else qv = longint'(l) + longint'(s) - ls;
    if (qv < 0) qv = 0;
    if (qv > longint'(OneQ)) qv = longint'(OneQ);
    q  = qv[16:0];
    pv = 2 * longint'(l) - qv;
    if (pv < 0) pv = 0;
    if (pv > longint'(OneQ)) pv = longint'(OneQ);
    p  = pv[16:0];
    r.red   = frac_to_byte(hue_ramp(p, q, FracBits'(h + ThirdQ)));
    r.green = frac_to_byte(hue_ramp(p, q, h));
    r.blue  = frac_to_byte(hue_ramp(p, q, FracBits'(h + TwoThirdsQ)));
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_channel(string chan, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", chan, got, want));
  endtask

  task automatic add_color(logic [HueBits-1:0] hue, logic [7:0] sat, logic [7:0] lit);
    hsl_word_t w;
    w.hue = hue;
    w.sat = sat;
    w.lit = lit;
    hsl_pending.push_back(w);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni                   = 1'b0;
    hsl_bus.valid            = 1'b0;
    hsl_bus.hue_turn         = '0;
    hsl_bus.saturation_level = '0;
    hsl_bus.lightness_level  = '0;
    rgb_bus.ready            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : drive_hsl
    hsl_word_t   next_color;
    int unsigned idle_roll;
    if (!rst_ni) begin
      hsl_bus.valid            <= 1'b0;
      hsl_bus.hue_turn         <= '0;
      hsl_bus.saturation_level <= '0;
      hsl_bus.lightness_level  <= '0;
      words_sent               <= 0;
    end else if (!hsl_bus.valid || hsl_bus.ready) begin
      idle_roll = $urandom_range(99);
      if (hsl_pending.size() != 0 &&
          !((gap_mode == GapSender && idle_roll < 88) ||
            (gap_mode == GapBoth && idle_roll < 24))) begin
        next_color = hsl_pending.pop_front();
        hsl_bus.valid            <= 1'b1;
        hsl_bus.hue_turn         <= next_color.hue;
        hsl_bus.saturation_level <= next_color.sat;
        hsl_bus.lightness_level  <= next_color.lit;
        rgb_due.push_back(predict_rgb(next_color));
        words_sent <= words_sent + 1;
      end else begin
        hsl_bus.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk_i or negedge rst_ni) begin : drive_rgb_ready
    int unsigned stall_roll;
    if (!rst_ni) begin
      rgb_bus.ready <= 1'b0;
    end else begin
      stall_roll = $urandom_range(99);
      rgb_bus.ready <= !((gap_mode == GapReceiver && stall_roll < 88) ||
                         (gap_mode == GapBoth && stall_roll < 24));
    end
  end

  always @(posedge clk_i) begin : check_rgb
    rgb_word_t want;
    if (rst_ni && rgb_bus.valid && rgb_bus.ready) begin
      if (rgb_due.size() == 0) begin
        report_mismatch($sformatf("unexpected rgb word %0d %0d %0d",
                                  rgb_bus.red_out, rgb_bus.green_out, rgb_bus.blue_out));
      end else begin
        want = rgb_due.pop_front();
        check_channel("red", rgb_bus.red_out, want.red);
        check_channel("green", rgb_bus.green_out, want.green);
        check_channel("blue", rgb_bus.blue_out, want.blue);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (hsl_bus.valid && hsl_bus.ready) || (rgb_bus.valid && rgb_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < QuietLimit) @(posedge clk_i);
    $display("FAIL hsl_to_rgb_converter_top");
    $finish;
  end

  initial begin : stimulus
    logic [HueBits-1:0] hue_marks [7];
    logic [HueBits-1:0] hue;
    logic [7:0]         sat;
    logic [7:0]         lit;
    hue_marks = '{16'd0, 16'd10923, 16'd21845, 16'd32768, 16'd43691, 16'd54614, 16'd65535};

    // gray, primaries, full and zero lightness
    add_color(16'd0, 8'd0, 8'd0);
    add_color(16'hFFFF, 8'd0, 8'd255);
    add_color(16'h5A5A, 8'd0, 8'd128);
    add_color(16'd0, 8'd255, 8'd128);
    add_color(16'd21845, 8'd255, 8'd128);
    add_color(16'd43691, 8'd255, 8'd128);
    add_color(16'd0, 8'd255, 8'd255);
    add_color(16'd0, 8'd255, 8'd0);
    add_color(16'd0, 8'd1, 8'd1);
    add_color(16'd65535, 8'd1, 8'd254);
    // ramp segment edges, lightness below and above one half
    add_color(16'd10922, 8'd255, 8'd127);
    add_color(16'd10923, 8'd255, 8'd127);
    add_color(16'd32767, 8'd200, 8'd60);
    add_color(16'd32768, 8'd200, 8'd60);
    add_color(16'd43690, 8'd255, 8'd200);
    add_color(16'd43691, 8'd255, 8'd200);
    add_color(16'd54613, 8'd128, 8'd128);
    add_color(16'd54614, 8'd128, 8'd128);
    add_color(16'd65535, 8'd255, 8'd128);
    add_color(16'd21844, 8'd170, 8'd90);
    add_color(16'd21846, 8'd85, 8'd230);
    add_color(16'hAAAA, 8'h55, 8'hAA);
    add_color(16'h5555, 8'hAA, 8'h55);

    for (int i = 0; i < RandomColors; i++) begin
      hue = HueBits'($urandom);
      if ($urandom_range(4) == 0) begin
        hue = HueBits'(hue_marks[$urandom_range(6)] + $urandom_range(2) - 1);
      end
      case ($urandom_range(9))
        0:       sat = 8'd0;
        1:       sat = 8'd255;
        default: sat = 8'($urandom_range(255));
      endcase
      case ($urandom_range(9))
        0:       lit = 8'd0;
        1:       lit = 8'd255;
        2:       lit = 8'(127 + $urandom_range(1));
        default: lit = 8'($urandom_range(255));
      endcase
      add_color(hue, sat, lit);
    end

    wait (rst_ni === 1'b1);
    while (hsl_pending.size() != 0 || rgb_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS hsl_to_rgb_converter_top");
    end else begin
      $display("FAIL hsl_to_rgb_converter_top");
    end
    $finish;
  end

endmodule
